// ===== design/fds_pkg.sv =====
// ----------------------------------------------------------------------------
// fds_pkg
// Shared types, constants and character helpers for the field declaration
// scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package fds_pkg;

    localparam int OFS_W           = 12;
    localparam int MAX_LEN_DEF     = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int KW_LEN          = 5;

    localparam logic [7:0] CHR_OPEN  = 8'h28;
    localparam logic [7:0] CHR_CLOSE = 8'h29;
    localparam logic [7:0] CHR_A     = 8'h61;

    typedef enum logic [2:0] {
        ST_OPEN      = 3'd0,
        ST_EXP_TYPE  = 3'd1,
        ST_RD_TYPE   = 3'd2,
        ST_EXP_NAME  = 3'd3,
        ST_RD_NAME   = 3'd4,
        ST_EXP_CLOSE = 3'd5
    } t_scan_state;

    typedef struct packed {
        logic blank;
        logic upper;
        logic lower;
        logic digit;
        logic open;
        logic close;
    } t_cls;

    typedef struct packed {
        logic [7:0]       chr;
        t_cls             cls;
        logic [OFS_W-1:0] off;
        logic             ovf;
        logic             last;
    } t_item;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        r.blank = c inside {8'h20, [8'h09:8'h0D]};
        r.upper = c inside {[8'h41:8'h5A]};
        r.lower = c inside {[8'h61:8'h7A]};
        r.digit = c inside {[8'h30:8'h39]};
        r.open  = (c == CHR_OPEN);
        r.close = (c == CHR_CLOSE);
        return r;
    endfunction

    // letters of the "array" keyword
    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h61;
            3'd1:    r = 8'h72;
            3'd2:    r = 8'h72;
            3'd3:    r = 8'h61;
            3'd4:    r = 8'h79;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/fds_front.sv =====
// ----------------------------------------------------------------------------
// fds_front
// Accepts characters, counts offsets with saturation and classifies each
// character before it is queued.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_front #(
    parameter int MAX_LEN = fds_pkg::MAX_LEN_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_character,
    input  wire logic          i_last_of_definition,
    input  wire logic          i_full,
    output logic               o_push,
    output fds_pkg::t_item     o_item
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int EW = (CW > fds_pkg::OFS_W) ? CW : fds_pkg::OFS_W;
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_LEN);
    localparam logic [CW-1:0] LAST_C = CW'(MAX_LEN - 1);

    logic [CW-1:0] r_char_offset;
    logic [CW-1:0] n_char_offset;
    logic [CW-1:0] w_off;
    logic [EW-1:0] w_off_ext;
    logic          w_sat;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid & ~i_full;

    assign w_sat     = (r_char_offset >= MAX_C);
    assign w_off     = w_sat ? LAST_C : r_char_offset;
    assign w_off_ext = EW'(w_off);

    always_comb begin
        n_char_offset = r_char_offset;
        if (o_push) begin
            if (i_last_of_definition) begin
                n_char_offset = '0;
            end else if (!w_sat) begin
                n_char_offset = r_char_offset + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_offset <= '0;
        end else begin
            r_char_offset <= n_char_offset;
        end
    end

    always_comb begin
        o_item.chr  = i_character;
        o_item.cls  = fds_pkg::classify(i_character);
        o_item.off  = w_off_ext[fds_pkg::OFS_W-1:0];
        o_item.ovf  = w_sat;
        o_item.last = i_last_of_definition;
    end

endmodule

`default_nettype wire

// ===== design/fds_queue.sv =====
// ----------------------------------------------------------------------------
// fds_queue
// Short first-in first-out queue of classified characters between the front
// and the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_queue #(
    parameter int DEPTH = fds_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fds_pkg::t_item  i_item,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_not_empty,
    output fds_pkg::t_item       o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    fds_pkg::t_item r_mem [DEPTH];
    logic [AW:0]    r_wr_ptr;
    logic [AW:0]    r_rd_ptr;
    logic [AW:0]    n_wr_ptr;
    logic [AW:0]    n_rd_ptr;

    // same slot with opposite lap bits means full
    assign o_full      = (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0])
                         && (r_wr_ptr[AW] != r_rd_ptr[AW]);
    assign o_not_empty = (r_wr_ptr != r_rd_ptr);
    assign o_item      = r_mem[r_rd_ptr[AW-1:0]];

    // pointers wrap at DEPTH so non power of two depths work too
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + (AW+1)'(1);
            if (r_wr_ptr[AW-1:0] == AW'(DEPTH - 1)) begin
                n_wr_ptr = {~r_wr_ptr[AW], {AW{1'b0}}};
            end
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + (AW+1)'(1);
            if (r_rd_ptr[AW-1:0] == AW'(DEPTH - 1)) begin
                n_rd_ptr = {~r_rd_ptr[AW], {AW{1'b0}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/fds_back.sv =====
// ----------------------------------------------------------------------------
// fds_back
// Six-state field scanner with the keyword compare and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_not_empty,
    input  wire fds_pkg::t_item              i_item,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [fds_pkg::OFS_W-1:0]        o_type_start,
    output logic [fds_pkg::OFS_W-1:0]        o_type_end,
    output logic [fds_pkg::OFS_W-1:0]        o_name_start,
    output logic [fds_pkg::OFS_W-1:0]        o_name_end,
    output logic                             o_offset_overflow
);

    localparam int OW = fds_pkg::OFS_W;

    fds_pkg::t_scan_state r_state;
    fds_pkg::t_scan_state n_state;
    logic                 r_halted;
    logic                 n_halted;
    logic                 r_kw;
    logic                 n_kw;
    logic [2:0]           r_prog;
    logic [2:0]           n_prog;
    logic                 r_mm;
    logic                 n_mm;
    logic                 r_ovf_seen;
    logic                 n_ovf_seen;
    logic [OW-1:0]        r_type_start;
    logic [OW-1:0]        n_type_start;
    logic [OW-1:0]        r_type_end;
    logic [OW-1:0]        n_type_end;
    logic [OW-1:0]        r_name_start;
    logic [OW-1:0]        n_name_start;
    logic [OW-1:0]        r_name_end;
    logic [OW-1:0]        n_name_end;
    logic                 r_out_valid;
    logic                 w_emit;
    logic                 w_alnum;
    logic                 w_kw_done;
    logic                 w_feed_ok;
    logic                 w_begin_ok;
    fds_pkg::t_cls        w_cls;

    assign o_pop     = i_not_empty & (~r_out_valid | ~i_out_stall);
    assign w_cls     = i_item.cls;
    assign w_alnum   = w_cls.upper | w_cls.lower | w_cls.digit;
    assign w_kw_done = ~r_mm & (r_prog == 3'(fds_pkg::KW_LEN));
    assign w_feed_ok = ~r_mm & (r_prog < 3'(fds_pkg::KW_LEN))
                       & (i_item.chr == fds_pkg::kw_char(r_prog));
    assign w_begin_ok = (i_item.chr == fds_pkg::CHR_A);

    // next scan state
    always_comb begin
        n_state = r_state;
        if (o_pop && !r_halted) begin
            case (r_state)
                fds_pkg::ST_EXP_TYPE: begin
                    if (w_cls.upper || w_cls.lower) begin
                        n_state = fds_pkg::ST_RD_TYPE;
                    end
                end
                fds_pkg::ST_RD_TYPE: begin
                    if (w_cls.blank) begin
                        n_state = fds_pkg::ST_EXP_NAME;
                    end
                end
                fds_pkg::ST_EXP_NAME: begin
                    if (!w_cls.blank) begin
                        if (!r_kw && w_cls.lower) begin
                            n_state = fds_pkg::ST_RD_NAME;
                        end else if (r_kw && w_alnum) begin
                            n_state = w_kw_done ? fds_pkg::ST_RD_TYPE
                                                : fds_pkg::ST_RD_NAME;
                        end
                    end
                end
                fds_pkg::ST_RD_NAME: begin
                    if (!w_alnum) begin
                        if (w_cls.close) begin
                            n_state = fds_pkg::ST_OPEN;
                        end else if (w_cls.blank) begin
                            n_state = fds_pkg::ST_EXP_CLOSE;
                        end
                    end
                end
                fds_pkg::ST_EXP_CLOSE: begin
                    if (w_cls.close) begin
                        n_state = fds_pkg::ST_OPEN;
                    end
                end
                default: begin
                    if (w_cls.open) begin
                        n_state = fds_pkg::ST_EXP_TYPE;
                    end
                end
            endcase
        end
        if (o_pop && i_item.last) begin
            n_state = fds_pkg::ST_OPEN;
        end
    end

    // datapath updates and result
    always_comb begin
        n_halted     = r_halted;
        n_kw         = r_kw;
        n_prog       = r_prog;
        n_mm         = r_mm;
        n_ovf_seen   = r_ovf_seen;
        n_type_start = r_type_start;
        n_type_end   = r_type_end;
        n_name_start = r_name_start;
        n_name_end   = r_name_end;
        w_emit       = 1'b0;
        if (o_pop) begin
            n_ovf_seen = r_ovf_seen | i_item.ovf;
            if (!r_halted) begin
                case (r_state)
                    fds_pkg::ST_EXP_TYPE: begin
                        if (w_cls.upper || w_cls.lower) begin
                            n_kw         = w_cls.lower;
                            n_type_start = i_item.off;
                            n_prog       = w_begin_ok ? 3'd1 : 3'd0;
                            n_mm         = ~w_begin_ok;
                        end
                    end
                    fds_pkg::ST_RD_TYPE: begin
                        if (w_cls.blank) begin
                            n_type_end = i_item.off;
                        end else if (w_alnum) begin
                            if (w_feed_ok) begin
                                n_prog = r_prog + 3'd1;
                            end else begin
                                n_mm = 1'b1;
                            end
                        end else begin
                            n_halted = 1'b1;
                        end
                    end
                    fds_pkg::ST_EXP_NAME: begin
                        if (!w_cls.blank) begin
                            if (!r_kw && w_cls.lower) begin
                                n_name_start = i_item.off;
                            end else if (r_kw && w_alnum) begin
                                // after "array" this word is the element type
                                if (w_kw_done) begin
                                    n_type_start = i_item.off;
                                    n_prog       = w_begin_ok ? 3'd1 : 3'd0;
                                    n_mm         = ~w_begin_ok;
                                end else begin
                                    n_name_start = i_item.off;
                                end
                            end else begin
                                n_halted = 1'b1;
                            end
                        end
                    end
                    fds_pkg::ST_RD_NAME: begin
                        if (!w_alnum) begin
                            if (w_cls.close) begin
                                n_name_end = i_item.off;
                                w_emit     = 1'b1;
                            end else if (w_cls.blank) begin
                                n_name_end = i_item.off;
                            end else begin
                                n_halted = 1'b1;
                            end
                        end
                    end
                    fds_pkg::ST_EXP_CLOSE: begin
                        if (!w_cls.blank) begin
                            if (w_cls.close) begin
                                w_emit = 1'b1;
                            end else begin
                                n_halted = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_halted = r_halted;
                    end
                endcase
            end
            if (i_item.last) begin
                n_halted   = 1'b0;
                n_kw       = 1'b0;
                n_prog     = 3'd0;
                n_mm       = 1'b0;
                n_ovf_seen = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fds_pkg::ST_OPEN;
            r_halted    <= 1'b0;
            r_kw        <= 1'b0;
            r_prog      <= 3'd0;
            r_mm        <= 1'b0;
            r_ovf_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_halted   <= n_halted;
            r_kw       <= n_kw;
            r_prog     <= n_prog;
            r_mm       <= n_mm;
            r_ovf_seen <= n_ovf_seen;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_type_start <= n_type_start;
        r_type_end   <= n_type_end;
        r_name_start <= n_name_start;
        r_name_end   <= n_name_end;
        if (w_emit) begin
            o_type_start      <= n_type_start;
            o_type_end        <= n_type_end;
            o_name_start      <= n_name_start;
            o_name_end        <= n_name_end;
            // flag as seen before a final character clears it
            o_offset_overflow <= r_ovf_seen | i_item.ovf;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== design/field_declaration_scanner.sv =====
// A closing character's result passes through the queue and then the scanner's output register.
// Throughput: one character per cycle, sustained while the output is not stalled.
// The input stalls only when the queue between front and scanner (four entries by default) is full.
// Reset (i_rst_n low, synchronous) clears the offset counter, queue and scanner state.
// The final character of a definition returns the offset counter and scanner to reset.
// ----------------------------------------------------------------------------
// field_declaration_scanner
// Finds (Type name) field declarations in a class body and reports the
// offsets of the type and the name of each one.
// ----------------------------------------------------------------------------
`default_nettype none

module field_declaration_scanner #(
    parameter int MAX_LEN     = fds_pkg::MAX_LEN_DEF,
    parameter int QUEUE_DEPTH = fds_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_character,
    input  wire logic                        i_last_of_definition,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [fds_pkg::OFS_W-1:0]        o_type_start,
    output logic [fds_pkg::OFS_W-1:0]        o_type_end,
    output logic [fds_pkg::OFS_W-1:0]        o_name_start,
    output logic [fds_pkg::OFS_W-1:0]        o_name_end,
    output logic                             o_offset_overflow
);

    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_not_empty;
    fds_pkg::t_item w_front_item;
    fds_pkg::t_item w_queue_item;

    fds_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_character          (i_character),
        .i_last_of_definition (i_last_of_definition),
        .i_full               (w_full),
        .o_push               (w_push),
        .o_item               (w_front_item)
    );

    fds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_item      (w_front_item),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_not_empty (w_not_empty),
        .o_item      (w_queue_item)
    );

    fds_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_not_empty       (w_not_empty),
        .i_item            (w_queue_item),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_type_start      (o_type_start),
        .o_type_end        (o_type_end),
        .o_name_start      (o_name_start),
        .o_name_end        (o_name_end),
        .o_offset_overflow (o_offset_overflow)
    );

endmodule

`default_nettype wire
